// ===== src/dcaof_pkg.sv =====
// ----------------------------------------------------------------------------
// dcaof_pkg: shared types and constants
// Queue sizing, field widths, mode and status codes for the two-class
// age-ordered FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package dcaof_pkg;

  localparam int QueueDepth = 16;
  localparam int TagBits    = 16;

  localparam int ModeW    = 2;
  localparam int PayloadW = 16;
  localparam int StatusW  = 2;
  localparam int StampW   = 32;
  localparam int IdxW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW   = $clog2(QueueDepth + 1);
  localparam int TagW     = (TagBits < PayloadW) ? TagBits : PayloadW;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [TagW-1:0]   tag_t;
  typedef logic [StampW-1:0] stamp_t;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ     = 2'd0,
    MODE_DEQ_ANY = 2'd1,
    MODE_DEQ_DOG = 2'd2,
    MODE_DEQ_CAT = 2'd3
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  function automatic idx_t next_idx(input idx_t i);
    if (i == IdxW'(QueueDepth - 1)) begin
      return '0;
    end
    return i + idx_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/dcaof_req_if.sv =====
// ----------------------------------------------------------------------------
// dcaof_req_if: request channel
// Valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcaof_req_if;
  logic                             valid;
  logic                             ready;
  logic [dcaof_pkg::ModeW-1:0]      mode;
  logic                             kind;
  logic [dcaof_pkg::PayloadW-1:0]   payload;

  modport source (output valid, output mode, output kind, output payload, input ready);
  modport sink   (input valid, input mode, input kind, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/dcaof_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dcaof_rsp_if: response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcaof_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [dcaof_pkg::StatusW-1:0]    status;
  logic [dcaof_pkg::PayloadW-1:0]   out_payload;
  logic                             out_kind;
  logic [dcaof_pkg::StampW-1:0]     out_arrival;

  modport source (output valid, output status, output out_payload, output out_kind,
                  output out_arrival, input ready);
  modport sink   (input valid, input status, input out_payload, input out_kind,
                  input out_arrival, output ready);
endinterface

`default_nettype wire

// ===== src/dual_class_age_ordered_fifo.sv =====
// ----------------------------------------------------------------------------
// dual_class_age_ordered_fifo: two-class FIFO with oldest-first dequeue
// Cat and dog queues, each entry stamped with a wrapping arrival number;
// dequeue from one class or from the older of the two heads.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | mode, kind, payload
//  rsp     | out | valid/ready  | status, out_payload, out_kind, out_arrival
//
//  One request per cycle while the result is taken; a request passes the request register, then the result register.
//  Queue state updates as a request moves into the result register.
//  Reset clears pointers, counts and the arrival counter; entry storage is not cleared.
//  A stalled result holds; one more request is buffered behind it, then req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_class_age_ordered_fifo (
  input  wire logic   clk,
  input  wire logic   rst,
  dcaof_req_if.sink   req,
  dcaof_rsp_if.source rsp
);

  // request register
  logic                        s1_valid;
  dcaof_pkg::mode_t            s1_mode;
  logic                        s1_kind;
  dcaof_pkg::tag_t             s1_tag;
  logic                        s1_go;

  // queue state
  dcaof_pkg::tag_t   cat_tags   [dcaof_pkg::QueueDepth];
  dcaof_pkg::stamp_t cat_stamps [dcaof_pkg::QueueDepth];
  dcaof_pkg::tag_t   dog_tags   [dcaof_pkg::QueueDepth];
  dcaof_pkg::stamp_t dog_stamps [dcaof_pkg::QueueDepth];
  dcaof_pkg::idx_t   cat_head, cat_tail, dog_head, dog_tail;
  dcaof_pkg::count_t cat_count, dog_count;
  dcaof_pkg::stamp_t arrival_counter;

  // result register
  logic                        out_valid;
  dcaof_pkg::status_t          out_status;
  logic [dcaof_pkg::PayloadW-1:0] out_payload;
  logic                        out_kind;
  dcaof_pkg::stamp_t           out_arrival;

  // decode
  logic              cat_empty, dog_empty, cat_full, dog_full;
  dcaof_pkg::tag_t   cat_hd_tag, dog_hd_tag;
  dcaof_pkg::stamp_t cat_hd_stamp, dog_hd_stamp, stamp_diff, new_stamp;
  logic              do_push, push_dog, do_pop, pop_dog;
  dcaof_pkg::status_t res_status;
  logic [dcaof_pkg::PayloadW-1:0] res_payload;
  logic              res_kind;
  dcaof_pkg::stamp_t res_arrival;

  assign s1_go     = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode <= dcaof_pkg::mode_t'(req.mode);
      s1_kind <= req.kind;
      s1_tag  <= req.payload[dcaof_pkg::TagW-1:0];
    end
  end

  assign cat_empty    = (cat_count == '0);
  assign dog_empty    = (dog_count == '0);
  assign cat_full     = (cat_count >= dcaof_pkg::CountW'(dcaof_pkg::QueueDepth));
  assign dog_full     = (dog_count >= dcaof_pkg::CountW'(dcaof_pkg::QueueDepth));
  assign cat_hd_tag   = cat_tags[cat_head];
  assign dog_hd_tag   = dog_tags[dog_head];
  assign cat_hd_stamp = cat_stamps[cat_head];
  assign dog_hd_stamp = dog_stamps[dog_head];
  assign stamp_diff   = dog_hd_stamp - cat_hd_stamp;
  assign new_stamp    = arrival_counter + dcaof_pkg::stamp_t'(1);

  always_comb begin
    do_push = 1'b0;
    push_dog = s1_kind;
    do_pop = 1'b0;
    pop_dog = 1'b0;
    res_status = dcaof_pkg::ST_OK;
    case (s1_mode)
      dcaof_pkg::MODE_ENQ: begin
        if (s1_kind ? dog_full : cat_full) begin
          res_status = dcaof_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      dcaof_pkg::MODE_DEQ_ANY: begin
        if (cat_empty && dog_empty) begin
          res_status = dcaof_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
          pop_dog = cat_empty || (!dog_empty && stamp_diff[dcaof_pkg::StampW-1]);
        end
      end
      dcaof_pkg::MODE_DEQ_DOG: begin
        pop_dog = 1'b1;
        if (dog_empty) begin
          res_status = dcaof_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      dcaof_pkg::MODE_DEQ_CAT: begin
        if (cat_empty) begin
          res_status = dcaof_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        res_status = dcaof_pkg::ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    res_payload = '0;
    res_kind = 1'b0;
    res_arrival = '0;
    if (do_push) begin
      res_arrival = new_stamp;
    end else if (do_pop) begin
      res_kind = pop_dog;
      res_payload = dcaof_pkg::PayloadW'(pop_dog ? dog_hd_tag : cat_hd_tag);
      res_arrival = pop_dog ? dog_hd_stamp : cat_hd_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && do_push) begin
      if (push_dog) begin
        dog_tags[dog_tail]   <= s1_tag;
        dog_stamps[dog_tail] <= new_stamp;
      end else begin
        cat_tags[cat_tail]   <= s1_tag;
        cat_stamps[cat_tail] <= new_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cat_head <= '0;
      cat_tail <= '0;
      cat_count <= '0;
      dog_head <= '0;
      dog_tail <= '0;
      dog_count <= '0;
      arrival_counter <= '0;
    end else if (s1_go) begin
      if (do_push) begin
        arrival_counter <= new_stamp;
        if (push_dog) begin
          dog_tail <= dcaof_pkg::next_idx(dog_tail);
          dog_count <= dog_count + dcaof_pkg::count_t'(1);
        end else begin
          cat_tail <= dcaof_pkg::next_idx(cat_tail);
          cat_count <= cat_count + dcaof_pkg::count_t'(1);
        end
      end
      if (do_pop) begin
        if (pop_dog) begin
          dog_head <= dcaof_pkg::next_idx(dog_head);
          dog_count <= dog_count - dcaof_pkg::count_t'(1);
        end else begin
          cat_head <= dcaof_pkg::next_idx(cat_head);
          cat_count <= cat_count - dcaof_pkg::count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status  <= res_status;
      out_payload <= res_payload;
      out_kind    <= res_kind;
      out_arrival <= res_arrival;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_payload = out_payload;
  assign rsp.out_kind    = out_kind;
  assign rsp.out_arrival = out_arrival;

endmodule

`default_nettype wire
